FILE: design/assert_macros.svh
// Assertion macros for the checker file of the double-and-add unit.
// Depends on nothing; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, switched off while reset is held
`define MDAA_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Clocked assertion that also holds during reset
`define MDAA_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: design/mdaa_pkg.sv
// Package for the modular multiply (double-and-add) unit: widths, cell payload
// types and the modular add and shift functions. Depends on nothing.
`timescale 1ns / 1ps

package mdaa_pkg;

  // Operand width and number of multiplicand bits scanned (8 to 63)
  localparam int unsigned FieldW = 63;
  localparam int unsigned ScanW  = 63;

  // Stream data widths, rounded up to whole bytes
  localparam int unsigned InDataW  = ((3 * FieldW + 7) / 8) * 8;
  localparam int unsigned OutDataW = ((FieldW + 7) / 8) * 8;

  typedef logic [FieldW-1:0] field_t;

  // Payload of a reduction cell: b is shifted out MSB first into r
  typedef struct packed {
    field_t a;
    field_t b;
    field_t m;
    field_t r;
  } red_t;

  // Payload of a double-and-add cell: a is shifted out LSB first
  typedef struct packed {
    field_t a;
    field_t m;
    field_t dbl;
    field_t acc;
  } mul_t;

  // (x + y) mod m for x, y < m, one conditional subtraction
  function automatic field_t add_mod(field_t x, field_t y, field_t m);
    logic [FieldW:0] sum;
    logic [FieldW:0] diff;
    sum  = {1'b0, x} + {1'b0, y};
    diff = sum - {1'b0, m};
    return (sum >= {1'b0, m}) ? diff[FieldW-1:0] : sum[FieldW-1:0];
  endfunction

  // (2r + in_bit) mod m for r < m, one step of restoring reduction
  function automatic field_t shift_mod(field_t r, logic in_bit, field_t m);
    logic [FieldW:0] sum;
    logic [FieldW:0] diff;
    sum  = {r, in_bit};
    diff = sum - {1'b0, m};
    return (sum >= {1'b0, m}) ? diff[FieldW-1:0] : sum[FieldW-1:0];
  endfunction

endpackage

FILE: design/mdaa_reduce_cell.sv
// One cell of the reduction chain: folds the next multiplier bit into the
// running remainder modulo the modulus. Depends on mdaa_pkg.
`timescale 1ns / 1ps

module mdaa_reduce_cell (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           en_i,
  input  logic           valid_i,
  input  mdaa_pkg::red_t red_i,
  output logic           valid_o,
  output mdaa_pkg::red_t red_o
);

  mdaa_pkg::red_t red_d;
  mdaa_pkg::red_t red_q;
  logic           valid_q;

  // Shift the top multiplier bit into the remainder and reduce
  always_comb begin
    red_d.a = red_i.a;
    red_d.m = red_i.m;
    red_d.b = {red_i.b[mdaa_pkg::FieldW-2:0], 1'b0};
    red_d.r = mdaa_pkg::shift_mod(red_i.r, red_i.b[mdaa_pkg::FieldW-1], red_i.m);
  end

  // Advance the valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  // Advance the payload
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      red_q <= red_d;
    end
  end

  assign valid_o = valid_q;
  assign red_o   = red_q;

endmodule

FILE: design/mdaa_dbl_add_cell.sv
// One cell of the double-and-add chain: adds the doubled multiplier when the
// current multiplicand bit is set, then doubles it. Depends on mdaa_pkg.
`timescale 1ns / 1ps

module mdaa_dbl_add_cell (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           en_i,
  input  logic           valid_i,
  input  mdaa_pkg::mul_t mul_i,
  output logic           valid_o,
  output mdaa_pkg::mul_t mul_o
);

  mdaa_pkg::mul_t mul_d;
  mdaa_pkg::mul_t mul_q;
  logic           valid_q;

  // Accumulate on a set bit and double in parallel, both from the old value
  always_comb begin
    mul_d.m   = mul_i.m;
    mul_d.a   = {1'b0, mul_i.a[mdaa_pkg::FieldW-1:1]};
    mul_d.dbl = mdaa_pkg::add_mod(mul_i.dbl, mul_i.dbl, mul_i.m);
    mul_d.acc = mul_i.a[0] ? mdaa_pkg::add_mod(mul_i.acc, mul_i.dbl, mul_i.m)
                           : mul_i.acc;
  end

  // Advance the valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  // Advance the payload
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mul_q <= mul_d;
    end
  end

  assign valid_o = valid_q;
  assign mul_o   = mul_q;

endmodule

FILE: design/modular_multiply_double_and_add_unit.sv
// Top level of the modular multiply unit: reduction chain, double-and-add
// chain and output skid buffer. Depends on mdaa_pkg and both cell modules.
`timescale 1ns / 1ps

// Computes (multiplicand * multiplier) mod modulus on 63-bit unsigned operands
// and returns one result per transaction, in order. A row of FieldW reduction
// cells first brings the multiplier below the modulus, one bit per cell, then
// a row of ScanW double-and-add cells walks the multiplicand from bit 0 up.
// Every cell holds one transaction and hands it on each cycle the rows move, so
// the unit takes one transaction per cycle while s_axis_tready_o is high. Each
// result passes through the two cell rows and then the output register. A zero
// modulus gives zero. The whole row moves while the two-entry output skid buffer
// holds fewer than two results, so s_axis_tready_o only drops while both entries
// are full, and rises again the cycle after the output side takes one.
module modular_multiply_double_and_add_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Input stream
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  // tdata: multiplicand [62:0], multiplier [125:63], modulus [188:126], zero pad
  input  logic [mdaa_pkg::InDataW-1:0]  s_axis_tdata_i,
  // Output stream
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  // tdata: product_mod [62:0], zero pad
  output logic [mdaa_pkg::OutDataW-1:0] m_axis_tdata_o
);

  localparam int unsigned FieldW = mdaa_pkg::FieldW;
  localparam int unsigned ScanW  = mdaa_pkg::ScanW;

  logic                 en;
  logic [FieldW:0]      red_valid;
  mdaa_pkg::red_t       red_stage [FieldW+1];
  logic [ScanW:0]       mul_valid;
  mdaa_pkg::mul_t       mul_stage [ScanW+1];
  mdaa_pkg::field_t     product;
  logic                 push;
  logic                 pop;
  logic [1:0]           cnt_d;
  logic [1:0]           cnt_q;
  mdaa_pkg::field_t     skid0_q;
  mdaa_pkg::field_t     skid1_q;

  // Move the cell rows while the skid buffer can take one more result
  assign en              = ~cnt_q[1];
  assign s_axis_tready_o = en;

  // Unpack the input transaction into the head of the reduction row
  assign red_valid[0]   = s_axis_tvalid_i;
  assign red_stage[0].a = s_axis_tdata_i[FieldW-1:0];
  assign red_stage[0].b = s_axis_tdata_i[2*FieldW-1:FieldW];
  assign red_stage[0].m = s_axis_tdata_i[3*FieldW-1:2*FieldW];
  assign red_stage[0].r = '0;

  // Reduction row, multiplier MSB first
  for (genvar k = 0; k < FieldW; k++) begin : g_red
    mdaa_reduce_cell u_red (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (red_valid[k]),
      .red_i   (red_stage[k]),
      .valid_o (red_valid[k+1]),
      .red_o   (red_stage[k+1])
    );
  end

  // Hand the reduced multiplier to the double-and-add row
  assign mul_valid[0]     = red_valid[FieldW];
  assign mul_stage[0].a   = red_stage[FieldW].a;
  assign mul_stage[0].m   = red_stage[FieldW].m;
  assign mul_stage[0].dbl = red_stage[FieldW].r;
  assign mul_stage[0].acc = '0;

  // Double-and-add row, multiplicand LSB first
  for (genvar k = 0; k < ScanW; k++) begin : g_mul
    mdaa_dbl_add_cell u_mul (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (mul_valid[k]),
      .mul_i   (mul_stage[k]),
      .valid_o (mul_valid[k+1]),
      .mul_o   (mul_stage[k+1])
    );
  end

  // Force a zero result for a zero modulus
  assign product = (mul_stage[ScanW].m == '0) ? '0 : mul_stage[ScanW].acc;

  // Skid buffer occupancy
  assign push  = en & mul_valid[ScanW];
  assign pop   = (cnt_q != 2'd0) & m_axis_tready_i;
  assign cnt_d = cnt_q + {1'b0, push} - {1'b0, pop};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  // Hold results in the skid buffer; the head entry drives the output
  always_ff @(posedge clk_i) begin
    if (pop) begin
      if (cnt_q[1]) begin
        skid0_q <= skid1_q;
      end else if (push) begin
        skid0_q <= product;
      end
    end else if (push) begin
      if (cnt_q == 2'd0) begin
        skid0_q <= product;
      end else begin
        skid1_q <= product;
      end
    end
  end

  assign m_axis_tvalid_o = (cnt_q != 2'd0);
  assign m_axis_tdata_o  = {{(mdaa_pkg::OutDataW - FieldW){1'b0}}, skid0_q};

endmodule

FILE: design/mdaa_checker.sv
// Port-level checker for the modular multiply unit, bound to the top level.
// Depends on mdaa_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module mdaa_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          s_axis_tvalid_i,
  input logic                          s_axis_tready_o,
  input logic                          m_axis_tvalid_o,
  input logic                          m_axis_tready_i,
  input logic [mdaa_pkg::OutDataW-1:0] m_axis_tdata_o
);

  // Output transaction held while stalled
  `MDAA_ASSERT(a_out_valid_hold, clk_i, rst_ni, m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o, "output valid dropped while stalled")
  `MDAA_ASSERT(a_out_data_hold, clk_i, rst_ni, m_axis_tvalid_o && !m_axis_tready_i |=> $stable(m_axis_tdata_o), "output data changed while stalled")

  // Input back-pressure only comes from a full output side
  `MDAA_ASSERT(a_stall_needs_result, clk_i, rst_ni, !s_axis_tready_o |-> m_axis_tvalid_o, "input stalled with no result waiting")
  `MDAA_ASSERT(a_stall_persists, clk_i, rst_ni, !s_axis_tready_o && !m_axis_tready_i |=> !s_axis_tready_o, "input stall released without an output transaction")

  // No result shown while reset is held
  `MDAA_ASSERT_ALWAYS(a_reset_empty, clk_i, !rst_ni |-> !m_axis_tvalid_o, "output valid during reset")

endmodule

bind modular_multiply_double_and_add_unit mdaa_checker u_mdaa_checker (.*);
